/* rtl/core/glt_pkg.sv */
`timescale 1ns / 1ps
package glt_pkg;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_LINE_END  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		QUOTE_NONE  = 2'd0,
		QUOTE_DQ    = 2'd1,
		QUOTE_SLASH = 2'd2
	} quote_t;

	typedef enum logic {
		OP_CHAR     = 1'b0,
		OP_LINE_END = 1'b1
	} op_t;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_EQUAL     = 8'h3d;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_SEMI      = 8'h3b;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// results of one input beat, in order
	typedef struct packed {
		logic [1:0]       cnt;
		kind_t [2:0]      kinds;
		logic [7:0]       ch;
	} job_t;

endpackage

/* rtl/core/glt_front.sv */
`timescale 1ns / 1ps
module glt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              operation,
	input  logic [7:0]        char_code,
	output logic              push,
	output glt_pkg::job_t     job,
	input  logic              queue_ready
);

	glt_pkg::quote_t quote_q, quote_n;
	logic            esc_q, esc_n;
	logic            tok_q, tok_n;
	logic            start_q, start_n;
	logic            skip_q, skip_n;

	logic                    accept;
	logic [1:0]              n;
	glt_pkg::kind_t [2:0]    ks;
	glt_pkg::quote_t         mode;
	glt_pkg::quote_t         cur;
	logic                    is_sep;

	assign item_ready = queue_ready;
	assign accept     = item_valid && item_ready;

	always_comb begin
		n       = 2'd0;
		ks      = {3{glt_pkg::KIND_TOKEN_END}};
		quote_n = quote_q;
		esc_n   = esc_q;
		tok_n   = tok_q;
		start_n = start_q;
		skip_n  = skip_q;
		mode    = (char_code == glt_pkg::CH_DQUOTE) ? glt_pkg::QUOTE_DQ : glt_pkg::QUOTE_SLASH;
		cur     = quote_q;
		is_sep  = (char_code == glt_pkg::CH_SPACE) || (char_code == glt_pkg::CH_HASH)
			|| (char_code == glt_pkg::CH_EQUAL);
		job.ch  = char_code;
		if (operation == glt_pkg::OP_LINE_END) begin
			job.ch = glt_pkg::CH_BACKSLASH;
			if (!skip_q) begin
				if (esc_q) begin
					ks[n] = glt_pkg::KIND_CHAR;
					n     = n + 2'd1;
				end
				if (esc_q || tok_q) begin
					ks[n] = glt_pkg::KIND_TOKEN_END;
					n     = n + 2'd1;
				end
				ks[n] = glt_pkg::KIND_LINE_END;
				n     = n + 2'd1;
			end
			quote_n = glt_pkg::QUOTE_NONE;
			esc_n   = 1'b0;
			tok_n   = 1'b0;
			start_n = 1'b1;
			skip_n  = 1'b0;
		end else begin
			start_n = 1'b0;
			skip_n  = skip_q || (start_q && char_code == glt_pkg::CH_SEMI);
			if (skip_n) begin
				n = 2'd0;
			end else if (esc_q) begin
				esc_n = 1'b0;
				ks[n] = glt_pkg::KIND_CHAR;
				n     = n + 2'd1;
				tok_n = 1'b1;
			end else if (quote_q == glt_pkg::QUOTE_NONE && is_sep) begin
				if (tok_q) begin
					ks[n] = glt_pkg::KIND_TOKEN_END;
					n     = n + 2'd1;
					tok_n = 1'b0;
				end
				if (char_code != glt_pkg::CH_SPACE) begin
					ks[n] = glt_pkg::KIND_CHAR;
					n     = n + 2'd1;
					ks[n] = glt_pkg::KIND_TOKEN_END;
					n     = n + 2'd1;
				end
			end else if (char_code == glt_pkg::CH_DQUOTE || char_code == glt_pkg::CH_SLASH) begin
				if (quote_q == glt_pkg::QUOTE_NONE) begin
					quote_n = mode;
				end else if (cur == mode) begin
					quote_n = glt_pkg::QUOTE_NONE;
				end
				ks[n] = glt_pkg::KIND_CHAR;
				n     = n + 2'd1;
				tok_n = 1'b1;
			end else if (char_code == glt_pkg::CH_BACKSLASH) begin
				esc_n = 1'b1;
			end else begin
				ks[n] = glt_pkg::KIND_CHAR;
				n     = n + 2'd1;
				tok_n = 1'b1;
			end
		end
		job.cnt   = n;
		job.kinds = ks;
	end

	assign push = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= glt_pkg::QUOTE_NONE;
			esc_q   <= 1'b0;
			tok_q   <= 1'b0;
			start_q <= 1'b1;
			skip_q  <= 1'b0;
		end else if (accept) begin
			quote_q <= quote_n;
			esc_q   <= esc_n;
			tok_q   <= tok_n;
			start_q <= start_n;
			skip_q  <= skip_n;
		end
	end

endmodule

/* rtl/core/glt_queue.sv */
`timescale 1ns / 1ps
module glt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  glt_pkg::job_t     push_job,
	output logic              push_ready,
	input  logic              pop,
	output logic              head_valid,
	output glt_pkg::job_t     head_job
);

	glt_pkg::job_t                mem_q [glt_pkg::QUEUE_DEPTH];
	logic [glt_pkg::QUEUE_AW-1:0] wr_q, rd_q;
	logic [glt_pkg::QUEUE_AW:0]   fill_q;
	logic                         do_push, do_pop;

	assign push_ready = (fill_q != (glt_pkg::QUEUE_AW+1)'(glt_pkg::QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_job   = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/glt_back.sv */
`timescale 1ns / 1ps
module glt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  glt_pkg::job_t     head_job,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [1:0]        kind,
	output logic [7:0]        out_char,
	output logic              last
);

	logic [1:0]     idx_q;
	glt_pkg::kind_t cur_kind;
	logic           beat;

	assign cur_kind     = head_job.kinds[idx_q];
	assign result_valid = head_valid;
	assign kind         = cur_kind;
	assign out_char     = (cur_kind == glt_pkg::KIND_CHAR) ? head_job.ch : 8'd0;
	assign last         = (idx_q == head_job.cnt - 2'd1);
	assign beat         = result_valid && result_ready;
	assign pop          = beat && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (beat) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

/* rtl/core/grammar_line_tokenizer.sv */
`timescale 1ns / 1ps
// a result is offered from the job queue, which registers the jobs of each input beat
// throughput: one input beat per cycle while the 4-entry job queue has room,
// one result beat per cycle from the back end while result_ready is high; up to three results per input
// sustained rate is set by the back end, one result a cycle while result_ready is high
// reset: arst_n clears tokenizer state, queue pointers and result index at once
module grammar_line_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       operation,
	input  logic [7:0] char_code,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] kind,
	output logic [7:0] out_char,
	output logic       last
);

	logic          push, push_ready, pop, head_valid;
	glt_pkg::job_t job, head_job;

	glt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.operation   (operation),
		.char_code   (char_code),
		.push        (push),
		.job         (job),
		.queue_ready (push_ready)
	);

	glt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (job),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	glt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.out_char     (out_char),
		.last         (last)
	);

endmodule

/* rtl/core/glt_checker.sv */
`timescale 1ns / 1ps
module glt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       operation,
	input logic [7:0] char_code,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] kind,
	input logic [7:0] out_char,
	input logic       last
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind)
		&& $stable(out_char) && $stable(last))
		else $error("result beat changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> kind != 2'd3)
		else $error("undefined result kind");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != glt_pkg::KIND_CHAR |-> out_char == 8'd0)
		else $error("nonzero char on end beat");

	a_line_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == glt_pkg::KIND_LINE_END |-> last)
		else $error("line end not last result");

	// nothing shows up without an input beat before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !(item_valid && item_ready) |=> !result_valid)
		else $error("result without input beat");

endmodule

bind grammar_line_tokenizer glt_checker u_glt_checker (.*);

/* bench/tb_grammar_line_tokenizer.sv */
`timescale 1ns / 1ps
module tb_grammar_line_tokenizer;
	import glt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		kind_t      p_kind;
		logic [7:0] p_ch;
		logic       p_last;
	} tok_piece_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic       operation = OP_CHAR;
	logic [7:0] char_code = 8'h00;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_char;
	logic       last;

	tok_piece_t tok_out_q[$];
	quote_t     quote_st = QUOTE_NONE;
	bit         esc_pend = 1'b0;
	bit         tok_open = 1'b0;
	bit         line_start = 1'b1;
	bit         in_comment = 1'b0;
	bit         calm = 1'b0;
	int         errors = 0;
	int         beats_sent = 0;
	int         results_checked = 0;
	int         lines_seen = 0;
	int         tokens_seen = 0;
	int         cycles = 0;

	grammar_line_tokenizer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.operation   (operation),
		.char_code   (char_code),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind        (kind),
		.out_char    (out_char),
		.last        (last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
	end

	function void add_piece(kind_t k, logic [7:0] c);
		tok_piece_t p;
		p.p_kind = k;
		p.p_ch   = c;
		p.p_last = 1'b0;
		tok_out_q.insert(tok_out_q.size(), p);
		if (k == KIND_TOKEN_END)
			tokens_seen++;
	endfunction

	// expected results of one input beat
	function void tokenize_beat(logic op, logic [7:0] ch);
		int     start_size;
		bit     first;
		quote_t mode;
		start_size = tok_out_q.size();
		if (op == OP_LINE_END) begin
			if (!in_comment) begin
				if (esc_pend) begin
					add_piece(KIND_CHAR, CH_BACKSLASH);
					tok_open = 1'b1;
				end
				if (tok_open)
					add_piece(KIND_TOKEN_END, 8'h00);
				add_piece(KIND_LINE_END, 8'h00);
			end
			lines_seen++;
			quote_st   = QUOTE_NONE;
			esc_pend   = 1'b0;
			tok_open   = 1'b0;
			line_start = 1'b1;
			in_comment = 1'b0;
		end else begin
			first      = line_start;
			line_start = 1'b0;
			if (first && ch == CH_SEMI)
				in_comment = 1'b1;
			if (in_comment) begin
				// dropped line
			end else if (esc_pend) begin
				esc_pend = 1'b0;
				add_piece(KIND_CHAR, ch);
				tok_open = 1'b1;
			end else if (quote_st == QUOTE_NONE &&
			             (ch == CH_SPACE || ch == CH_HASH || ch == CH_EQUAL)) begin
				if (tok_open)
					add_piece(KIND_TOKEN_END, 8'h00);
				tok_open = 1'b0;
				if (ch != CH_SPACE) begin
					add_piece(KIND_CHAR, ch);
					add_piece(KIND_TOKEN_END, 8'h00);
				end
			end else if (ch == CH_DQUOTE || ch == CH_SLASH) begin
				mode = (ch == CH_DQUOTE) ? QUOTE_DQ : QUOTE_SLASH;
				if (quote_st == QUOTE_NONE)
					quote_st = mode;
				else if (quote_st == mode)
					quote_st = QUOTE_NONE;
				add_piece(KIND_CHAR, ch);
				tok_open = 1'b1;
			end else if (ch == CH_BACKSLASH) begin
				esc_pend = 1'b1;
			end else begin
				add_piece(KIND_CHAR, ch);
				tok_open = 1'b1;
			end
		end
		if (tok_out_q.size() > start_size)
			tok_out_q[tok_out_q.size() - 1].p_last = 1'b1;
	endfunction

	// results first: none can come from a beat taken at the same edge
	always @(posedge clk) begin
		tok_piece_t exp_p;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_checked++;
				if (tok_out_q.size() == 0) begin
					$display("%0t unexpected result kind %0d char %02h last %0b",
					         $time, kind, out_char, last);
					errors++;
				end else begin
					exp_p = tok_out_q.pop_front();
					if (kind !== exp_p.p_kind) begin
						$display("%0t kind mismatch: expected %0d actual %0d",
						         $time, exp_p.p_kind, kind);
						errors++;
					end
					if (out_char !== exp_p.p_ch) begin
						$display("%0t out_char mismatch: expected %02h actual %02h",
						         $time, exp_p.p_ch, out_char);
						errors++;
					end
					if (last !== exp_p.p_last) begin
						$display("%0t last mismatch: expected %0b actual %0b",
						         $time, exp_p.p_last, last);
						errors++;
					end
				end
			end
			if (item_valid && item_ready)
				tokenize_beat(operation, char_code);
		end
	end

	// called and returns at a falling edge
	task send_beat(op_t op, logic [7:0] ch);
		while (!calm && $urandom_range(0, 99) < 18) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		operation  <= op;
		char_code  <= ch;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task send_line(string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(OP_CHAR, s[i]);
		send_beat(OP_LINE_END, 8'($urandom_range(0, 255)));
	endtask

	task wait_drained();
		item_valid <= 1'b0;
		while (tok_out_q.size() != 0)
			@(negedge clk);
	endtask

	task test_plain_and_extremes();
		send_beat(OP_CHAR, "a");
		send_beat(OP_CHAR, CH_SPACE);
		send_beat(OP_CHAR, 8'h00);
		send_beat(OP_CHAR, CH_EQUAL);
		send_beat(OP_CHAR, 8'hff);
		send_beat(OP_LINE_END, 8'hff);
	endtask

	task test_quotes();
		send_line("#\" /\"");
		send_line("/#");
	endtask

	task test_comment_and_empty();
		send_line(";x ");
		send_beat(OP_LINE_END, 8'h00);
	endtask

	task test_escapes();
		send_line("\\#\\");
	endtask

	task test_drain_pause();
		send_line("k=v");
		wait_drained();
		send_line("x");
	endtask

	task test_random_lines(int n_beats, bit quiet);
		int         stop_at;
		int         len;
		int         r;
		logic [7:0] c;
		calm    = quiet;
		stop_at = beats_sent + n_beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				send_beat(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else begin
				len = $urandom_range(0, 8);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 35)
						c = 8'("a" + $urandom_range(0, 25));
					else if (r < 47)
						c = CH_SPACE;
					else if (r < 53)
						c = CH_HASH;
					else if (r < 58)
						c = CH_EQUAL;
					else if (r < 65)
						c = CH_DQUOTE;
					else if (r < 71)
						c = CH_SLASH;
					else if (r < 79)
						c = CH_BACKSLASH;
					else if (r < 83)
						c = CH_SEMI;
					else
						c = 8'($urandom_range(0, 255));
					send_beat(OP_CHAR, c);
				end
				send_beat(OP_LINE_END, 8'($urandom_range(0, 255)));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		int guard;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_plain_and_extremes();
		test_quotes();
		test_comment_and_empty();
		test_escapes();
		test_drain_pause();
		test_random_lines(35, 1'b0);
		test_random_lines(25, 1'b1);
		test_random_lines(20, 1'b0);

		wait_drained();
		guard = 0;
		while (guard < 20) begin
			@(posedge clk);
			guard++;
		end

		$display("tb: %0d beats sent over %0d lines, %0d results checked",
		         beats_sent, lines_seen, results_checked);
		$display("tb: quotes, escapes, comment and empty lines, symbols, %0d tokens",
		         tokens_seen);
		if (errors == 0 && tok_out_q.size() == 0) begin
			$display("tb: success");
		end else begin
			if (tok_out_q.size() != 0)
				$display("%0t %0d expected results never arrived", $time, tok_out_q.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
